// File: design/glw_pkg.sv
// Shared types, constants and saturating helpers for the greedy line wrapper.
package glw_pkg;

	localparam int MAX_RUNS    = 64;
	localparam int RUN_W       = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int RUN_CNT_W   = $clog2(MAX_RUNS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] MAX16 = 16'hFFFF;
	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_GLYPH = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_ROW     = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_GLYPH,
		OP_FLUSH
	} glw_op_kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] text_index;
		logic [7:0]  text_length;
		logic [15:0] advance_x;
		logic        breakable;
		logic [15:0] run_end;
	} glw_req_t;

	typedef struct packed {
		logic        record_kind;
		logic [5:0]  run_index;
		logic [15:0] line_number;
		logic [23:0] x_start;
		logic [23:0] seg_width;
		logic [15:0] text_start;
		logic [15:0] text_bytes;
		logic [15:0] glyph_start;
		logic [15:0] glyph_count;
		logic [15:0] segment_start;
		logic [15:0] segment_count;
		logic        last;
	} glw_rec_t;

	typedef struct packed {
		glw_op_kind_t kind;
		logic [15:0]  text_index;
		logic [7:0]   text_length;
		logic [15:0]  advance_x;
		logic         breakable;
		logic [15:0]  run_end;
	} glw_op_t;

	typedef struct packed {
		logic    valid;
		glw_op_t op;
	} glw_head_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? MAX16 : s[15:0];
	endfunction

	function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [15:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[24] ? MAX24 : s[23:0];
	endfunction

	function automatic logic [15:0] floor_sub16(input logic [15:0] a, input logic [15:0] b);
		return (a >= b) ? (a - b) : 16'd0;
	endfunction

endpackage

// File: design/glw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/glw_front.sv
// Front end: accepts requests, decodes them and queues them for the back end.
module glw_front import glw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  glw_req_t  req_data,
	output glw_head_t head,
	input  logic      pop
);

	glw_op_t           queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	glw_op_t dec_op;
	logic    dec_known;
	logic    push;
	logic    do_pop;

	always_comb begin
		dec_op.kind        = OP_LOAD;
		dec_op.text_index  = req_data.text_index;
		dec_op.text_length = req_data.text_length;
		dec_op.advance_x   = req_data.advance_x;
		dec_op.breakable   = req_data.breakable;
		dec_op.run_end     = req_data.run_end;
		dec_known          = 1'b1;
		unique case (req_data.req_type)
			REQ_LOAD:  dec_op.kind = OP_LOAD;
			REQ_GLYPH: dec_op.kind = OP_GLYPH;
			REQ_FLUSH: dec_op.kind = OP_FLUSH;
			default:   dec_known = 1'b0;
		endcase
	end

	// Unknown request codes are accepted and dropped here.
	assign req_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = req_valid && !req_stall && dec_known;
	assign do_pop    = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.op    = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/glw_back.sv
// Back end: wrapping state, run table, record generation and output staging.
module glw_back import glw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  glw_head_t   head,
	output logic        pop,
	input  logic        cfg_valid,
	input  logic [23:0] cfg_data,
	output logic        rec_valid,
	input  logic        rec_stall,
	output glw_rec_t    rec_data
);

	logic [23:0]          line_width_q;
	logic [RUN_CNT_W-1:0] run_count_q;
	logic [RUN_CNT_W-1:0] cur_run_q;
	logic [23:0]          run_x_q;
	logic [23:0]          seg_x_q;
	logic [15:0]          glyph_cnt_q;
	logic [15:0]          seg_glyph_q;
	logic [15:0]          seg_byte_q;
	logic [15:0]          line_q;
	logic [15:0]          segs_q;
	logic [15:0]          row_byte_q;
	logic [15:0]          row_bytes_q;
	logic [15:0]          row_glyph_q;
	logic [15:0]          row_glyphs_q;
	logic [15:0]          row_seg_q;
	logic [15:0]          row_segs_q;
	logic                 end_ok_q;
	glw_rec_t             out_q;
	logic                 out_v_q;
	glw_rec_t             pend_q;
	logic                 pend_v_q;

	glw_op_t              op;
	logic [15:0]          run_end_rd;
	logic                 seg_open;
	logic [15:0]          seg_byte_eff;
	logic                 run_flush;
	logic                 width_flush;
	logic [24:0]          sum_x;
	logic [15:0]          segs_inc;
	logic [15:0]          row_segs_inc;
	glw_rec_t             seg_rec;
	glw_rec_t             row_rec;
	glw_rec_t             r0;
	glw_rec_t             r1;
	logic [1:0]           nres;
	logic                 out_free;
	logic                 fire;
	logic                 load_we;
	logic [RUN_CNT_W-1:0] cur_run_d;

	assign op = head.op;

	// The read port follows the next value of the run index, so the end of the
	// current run is ready every cycle; only a write to that entry makes it stale.
	glw_ram #(.WIDTH(16), .DEPTH(MAX_RUNS)) u_run_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (run_count_q[RUN_W-1:0]),
		.wdata (op.run_end),
		.raddr (cur_run_d[RUN_W-1:0]),
		.rdata (run_end_rd)
	);

	always_comb begin
		seg_open     = glyph_cnt_q > seg_glyph_q;
		seg_byte_eff = (op.kind == OP_GLYPH && !seg_open) ? op.text_index : seg_byte_q;
		sum_x        = {1'b0, run_x_q} + {9'd0, op.advance_x};
		run_flush    = (cur_run_q < run_count_q) && (op.text_index >= run_end_rd);
		width_flush  = (sum_x > {1'b0, line_width_q}) && op.breakable && seg_open;
		segs_inc     = sat_add16(segs_q, 16'd1);
		row_segs_inc = sat_add16(row_segs_q, 16'd1);

		seg_rec               = '0;
		seg_rec.record_kind   = KIND_SEGMENT;
		seg_rec.run_index     = 6'(cur_run_q);
		seg_rec.line_number   = line_q;
		seg_rec.x_start       = seg_x_q;
		seg_rec.seg_width     = (run_x_q >= seg_x_q) ? (run_x_q - seg_x_q) : 24'd0;
		seg_rec.text_start    = seg_byte_eff;
		seg_rec.text_bytes    = floor_sub16(op.text_index, seg_byte_eff);
		seg_rec.glyph_start   = seg_glyph_q;
		seg_rec.glyph_count   = floor_sub16(glyph_cnt_q, seg_glyph_q);
		seg_rec.last          = 1'b1;

		row_rec               = '0;
		row_rec.record_kind   = KIND_ROW;
		row_rec.line_number   = line_q;
		row_rec.text_start    = row_byte_q;
		row_rec.text_bytes    = row_bytes_q;
		row_rec.glyph_start   = row_glyph_q;
		row_rec.glyph_count   = row_glyphs_q;
		row_rec.segment_start = row_seg_q;
		row_rec.segment_count = row_segs_q;
		row_rec.last          = 1'b1;

		r0   = seg_rec;
		r1   = row_rec;
		nres = 2'd0;
		case (op.kind)
			OP_GLYPH: begin
				if (width_flush) begin
					nres                  = 2'd2;
					r0.last               = 1'b0;
					r1.segment_count      = row_segs_inc;
				end else if (run_flush) begin
					nres = 2'd1;
				end
			end
			OP_FLUSH: begin
				if (seg_open) begin
					nres             = 2'd2;
					r0.last          = 1'b0;
					r1.segment_count = row_segs_inc;
				end else begin
					nres = 2'd1;
					r0   = row_rec;
				end
			end
			default: nres = 2'd0;
		endcase
	end

	assign out_free = !out_v_q || !rec_stall;
	assign fire     = head.valid && (op.kind != OP_GLYPH || end_ok_q) &&
	                  (nres == 2'd0 || (!pend_v_q && out_free));
	assign pop      = fire;
	assign load_we  = fire && (op.kind == OP_LOAD) && (run_count_q < RUN_CNT_W'(MAX_RUNS));

	always_comb begin
		cur_run_d = cur_run_q;
		if (fire && op.kind == OP_GLYPH && run_flush) begin
			cur_run_d = cur_run_q + 1'b1;
		end else if (fire && op.kind == OP_FLUSH) begin
			cur_run_d = '0;
		end
	end

	assign rec_valid = out_v_q;
	assign rec_data  = out_q;

	always_ff @(posedge clk) begin
		if (fire && nres != 2'd0) begin
			out_q <= r0;
			if (nres == 2'd2) begin
				pend_q <= r1;
			end
		end else if (out_free && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= MAX24;
			run_count_q  <= '0;
			cur_run_q    <= '0;
			run_x_q      <= '0;
			seg_x_q      <= '0;
			glyph_cnt_q  <= '0;
			seg_glyph_q  <= '0;
			seg_byte_q   <= '0;
			line_q       <= '0;
			segs_q       <= '0;
			row_byte_q   <= '0;
			row_bytes_q  <= '0;
			row_glyph_q  <= '0;
			row_glyphs_q <= '0;
			row_seg_q    <= '0;
			row_segs_q   <= '0;
			end_ok_q     <= 1'b0;
			out_v_q      <= 1'b0;
			pend_v_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				line_width_q <= cfg_data;
			end
			cur_run_q <= cur_run_d;
			end_ok_q  <= !(load_we && (run_count_q[RUN_W-1:0] == cur_run_d[RUN_W-1:0]));

			if (fire) begin
				case (op.kind)
					OP_LOAD: begin
						if (load_we) begin
							run_count_q <= run_count_q + 1'b1;
						end
					end
					OP_GLYPH: begin
						glyph_cnt_q <= sat_add16(glyph_cnt_q, 16'd1);
						if (run_flush || width_flush) begin
							segs_q      <= segs_inc;
							seg_glyph_q <= glyph_cnt_q;
							seg_byte_q  <= op.text_index;
						end else begin
							seg_byte_q <= seg_byte_eff;
						end
						if (width_flush) begin
							line_q       <= sat_add16(line_q, 16'd1);
							row_byte_q   <= op.text_index;
							row_bytes_q  <= {8'd0, op.text_length};
							row_glyph_q  <= glyph_cnt_q;
							row_glyphs_q <= 16'd1;
							row_seg_q    <= segs_inc;
							row_segs_q   <= '0;
							seg_x_q      <= '0;
							run_x_q      <= {8'd0, op.advance_x};
						end else begin
							if (run_flush) begin
								row_segs_q <= row_segs_inc;
								seg_x_q    <= run_x_q;
							end
							run_x_q      <= sat_add24(run_x_q, op.advance_x);
							row_bytes_q  <= sat_add16(row_bytes_q, {8'd0, op.text_length});
							row_glyphs_q <= sat_add16(row_glyphs_q, 16'd1);
						end
					end
					OP_FLUSH: begin
						// New paragraph: everything but the width limit and the table.
						run_count_q  <= '0;
						run_x_q      <= '0;
						seg_x_q      <= '0;
						glyph_cnt_q  <= '0;
						seg_glyph_q  <= '0;
						seg_byte_q   <= '0;
						line_q       <= '0;
						segs_q       <= '0;
						row_byte_q   <= '0;
						row_bytes_q  <= '0;
						row_glyph_q  <= '0;
						row_glyphs_q <= '0;
						row_seg_q    <= '0;
						row_segs_q   <= '0;
					end
					default: begin
					end
				endcase
			end

			if (fire && nres != 2'd0) begin
				out_v_q  <= 1'b1;
				pend_v_q <= (nres == 2'd2);
			end else if (out_free) begin
				out_v_q  <= pend_v_q;
				pend_v_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/greedy_line_wrapper.sv
// A request passes through the front-end queue and the output register before
// its first record is on the output. Throughput: one request per cycle unless
// the output stalls; a request with two records holds the next record-making
// request until its second record leaves the pending register, and a glyph right
// after a load into the current run's table entry waits for the registered read.
// Reset clears all wrapping state and sets line_width to its maximum; the run
// table holds no defined contents until loaded.
module greedy_line_wrapper import glw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  glw_req_t    req_data,
	output logic        rec_valid,
	input  logic        rec_stall,
	output glw_rec_t    rec_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	glw_head_t head;
	logic      pop;

	assign cfg_ready = 1'b1;

	glw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.head      (head),
		.pop       (pop)
	);

	glw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data)
	);

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for greedy_line_wrapper: a line-layout predictor checks every record.
module testbench;
	import glw_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 330;

	class layout_scoreboard;
		logic [23:0] width_limit;
		logic [15:0] run_ends [MAX_RUNS];
		logic [RUN_CNT_W-1:0] runs_loaded;
		logic [RUN_CNT_W-1:0] run_ptr;
		logic [23:0] pen_x;
		logic [23:0] seg_x0;
		logic [15:0] glyph_seen;
		logic [15:0] seg_glyph0;
		logic [15:0] seg_byte0;
		logic [15:0] line_no;
		logic [15:0] segs_made;
		logic [15:0] row_byte0;
		logic [15:0] row_bytes;
		logic [15:0] row_glyph0;
		logic [15:0] row_glyphs;
		logic [15:0] row_seg0;
		logic [15:0] row_segs;
		glw_rec_t due_records [$];
		int errors;

		function new();
			width_limit = MAX24;
			errors = 0;
			new_paragraph();
		endfunction

		function logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
			return (a > MAX16 - b) ? MAX16 : a + b;
		endfunction

		function logic [23:0] sat24(logic [23:0] a, logic [15:0] b);
			return (a > MAX24 - {8'd0, b}) ? MAX24 : a + {8'd0, b};
		endfunction

		function void new_paragraph();
			runs_loaded = '0;
			run_ptr = '0;
			pen_x = '0;
			seg_x0 = '0;
			glyph_seen = '0;
			seg_glyph0 = '0;
			seg_byte0 = '0;
			line_no = '0;
			segs_made = '0;
			row_byte0 = '0;
			row_bytes = '0;
			row_glyph0 = '0;
			row_glyphs = '0;
			row_seg0 = '0;
			row_segs = '0;
		endfunction

		function void set_width(logic [23:0] w);
			width_limit = w;
		endfunction

		function int outstanding();
			return due_records.size();
		endfunction

		function glw_rec_t close_segment(logic [15:0] end_byte);
			glw_rec_t rec;
			rec = '0;
			rec.record_kind = KIND_SEGMENT;
			rec.run_index = run_ptr[5:0];
			rec.line_number = line_no;
			rec.x_start = seg_x0;
			rec.seg_width = (pen_x >= seg_x0) ? pen_x - seg_x0 : '0;
			rec.text_start = seg_byte0;
			rec.text_bytes = (end_byte >= seg_byte0) ? end_byte - seg_byte0 : '0;
			rec.glyph_start = seg_glyph0;
			rec.glyph_count = (glyph_seen >= seg_glyph0) ? glyph_seen - seg_glyph0 : '0;
			segs_made = sat16(segs_made, 16'd1);
			row_segs = sat16(row_segs, 16'd1);
			return rec;
		endfunction

		function glw_rec_t close_row();
			glw_rec_t rec;
			rec = '0;
			rec.record_kind = KIND_ROW;
			rec.line_number = line_no;
			rec.text_start = row_byte0;
			rec.text_bytes = row_bytes;
			rec.glyph_start = row_glyph0;
			rec.glyph_count = row_glyphs;
			rec.segment_start = row_seg0;
			rec.segment_count = row_segs;
			return rec;
		endfunction

		// Predicts the records of one accepted request; returns 1 if the block ignores it.
		function bit apply_request(glw_req_t r);
			glw_rec_t made [2];
			int n;
			int i;
			bit run_hit;
			bit width_hit;
			logic [24:0] reach;
			n = 0;
			case (r.req_type)
				REQ_LOAD: begin
					if (runs_loaded >= RUN_CNT_W'(MAX_RUNS))
						return 1'b1;
					run_ends[runs_loaded[5:0]] = r.run_end;
					runs_loaded++;
					return 1'b0;
				end
				REQ_FLUSH: begin
					if (glyph_seen > seg_glyph0) begin
						made[n] = close_segment(r.text_index);
						n++;
					end
					made[n] = close_row();
					n++;
					new_paragraph();
				end
				REQ_GLYPH: begin
					if (glyph_seen == seg_glyph0)
						seg_byte0 = r.text_index;
					run_hit = 1'b0;
					if (run_ptr < runs_loaded)
						run_hit = (r.text_index >= run_ends[run_ptr[5:0]]);
					reach = {1'b0, pen_x} + {9'd0, r.advance_x};
					width_hit = (reach > {1'b0, width_limit}) && r.breakable &&
						(glyph_seen > seg_glyph0);
					if (run_hit || width_hit) begin
						made[n] = close_segment(r.text_index);
						n++;
						if (width_hit) begin
							made[n] = close_row();
							n++;
							line_no = sat16(line_no, 16'd1);
							row_byte0 = r.text_index;
							row_bytes = '0;
							row_glyph0 = glyph_seen;
							row_glyphs = '0;
							row_seg0 = segs_made;
							row_segs = '0;
							pen_x = '0;
						end
						seg_x0 = pen_x;
						seg_glyph0 = glyph_seen;
						seg_byte0 = r.text_index;
						if (run_hit)
							run_ptr++;
					end
					pen_x = sat24(pen_x, r.advance_x);
					row_bytes = sat16(row_bytes, {8'd0, r.text_length});
					row_glyphs = sat16(row_glyphs, 16'd1);
					glyph_seen = sat16(glyph_seen, 16'd1);
				end
				default: return 1'b1;
			endcase
			if (n > 0)
				made[n-1].last = 1'b1;
			for (i = 0; i < n; i++)
				due_records = {due_records, made[i]};
			return 1'b0;
		endfunction

		task report(string what, logic [23:0] got, logic [23:0] want);
			if (errors < 100)
				$display("mismatch: %s got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task match_record(glw_rec_t got);
			glw_rec_t want;
			if (due_records.size() == 0) begin
				report("record with none due, text_start", 24'(got.text_start), '0);
				return;
			end
			want = due_records.pop_front();
			if (got.record_kind !== want.record_kind)
				report("record_kind", 24'(got.record_kind), 24'(want.record_kind));
			if (got.run_index !== want.run_index)
				report("run_index", 24'(got.run_index), 24'(want.run_index));
			if (got.line_number !== want.line_number)
				report("line_number", 24'(got.line_number), 24'(want.line_number));
			if (got.x_start !== want.x_start)
				report("x_start", got.x_start, want.x_start);
			if (got.seg_width !== want.seg_width)
				report("seg_width", got.seg_width, want.seg_width);
			if (got.text_start !== want.text_start)
				report("text_start", 24'(got.text_start), 24'(want.text_start));
			if (got.text_bytes !== want.text_bytes)
				report("text_bytes", 24'(got.text_bytes), 24'(want.text_bytes));
			if (got.glyph_start !== want.glyph_start)
				report("glyph_start", 24'(got.glyph_start), 24'(want.glyph_start));
			if (got.glyph_count !== want.glyph_count)
				report("glyph_count", 24'(got.glyph_count), 24'(want.glyph_count));
			if (got.segment_start !== want.segment_start)
				report("segment_start", 24'(got.segment_start), 24'(want.segment_start));
			if (got.segment_count !== want.segment_count)
				report("segment_count", 24'(got.segment_count), 24'(want.segment_count));
			if (got.last !== want.last)
				report("last", 24'(got.last), 24'(want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	glw_req_t    req_data;
	logic        rec_valid;
	logic        rec_stall;
	glw_rec_t    rec_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;

	layout_scoreboard sb;
	int cycle_count = 0;
	int items_done = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	greedy_line_wrapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rec_valid && !rec_stall)
			sb.match_record(rec_data);
	end

	// Output back-pressure comes in bursts; none once the run has gone calm.
	initial begin
		rec_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 10);
			rec_stall = (stall_left > 0);
		end
	end

	function automatic glw_req_t stray_req();
		glw_req_t r;
		r.req_type = 2'($urandom);
		r.text_index = 16'($urandom);
		r.text_length = 8'($urandom);
		r.advance_x = 16'($urandom);
		r.breakable = 1'($urandom);
		r.run_end = 16'($urandom);
		return r;
	endfunction

	function automatic glw_req_t load_req(logic [15:0] end_pos);
		glw_req_t r;
		r = stray_req();
		r.req_type = REQ_LOAD;
		r.run_end = end_pos;
		return r;
	endfunction

	function automatic glw_req_t glyph_req(logic [15:0] idx, logic [7:0] len,
			logic [15:0] adv, logic brk);
		glw_req_t r;
		r = stray_req();
		r.req_type = REQ_GLYPH;
		r.text_index = idx;
		r.text_length = len;
		r.advance_x = adv;
		r.breakable = brk;
		return r;
	endfunction

	function automatic glw_req_t end_req(logic [15:0] total);
		glw_req_t r;
		r = stray_req();
		r.req_type = REQ_FLUSH;
		r.text_index = total;
		return r;
	endfunction

	task automatic send(input glw_req_t r);
		int gap;
		bit skipped;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 10);
		if (gap > 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			req_data = stray_req();
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		req_data = r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		skipped = sb.apply_request(r);
		if (!skipped)
			items_done++;
	endtask

	// Holds off new requests until every due record has come, plus a settling pause.
	task automatic drain(input int settle);
		@(negedge clk);
		req_valid = 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_width(input logic [23:0] w);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_width(w);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic paragraph(input bit crowded);
		int nruns;
		int nglyphs;
		int i;
		logic [15:0] run_pos;
		logic [15:0] pos;
		logic [7:0] len;
		logic [15:0] adv;
		logic brk;
		if (crowded || $urandom_range(0, 19) == 0)
			nruns = $urandom_range(60, 70);
		else
			nruns = $urandom_range(0, 6);
		run_pos = '0;
		for (i = 0; i < nruns; i++) begin
			run_pos = run_pos + 16'($urandom_range(1, 40));
			send(load_req(run_pos));
		end
		nglyphs = $urandom_range(1, 30);
		pos = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd0;
		for (i = 0; i < nglyphs; i++) begin
			len = ($urandom_range(0, 29) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
			adv = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
			brk = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 29) == 0)
				send(stray_req());
			send(glyph_req(pos, len, adv, brk));
			pos = pos + {8'd0, len};
		end
		send(end_req(($urandom_range(0, 15) == 0) ? 16'($urandom) : pos));
	endtask

	// Enough wide, long glyphs to pin the pen position and the row byte total at their tops.
	task automatic long_paragraph();
		int i;
		logic [15:0] pos;
		send(end_req(16'd0));
		pos = '0;
		for (i = 0; i < 270; i++) begin
			send(glyph_req(pos, 8'hFF, MAX16, ($urandom_range(0, 40) == 0)));
			pos = pos + 16'd255;
		end
		send(end_req(pos));
	endtask

	initial begin
		logic [23:0] phase_width;
		glw_req_t r;
		int ph;
		int target;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No run is loaded yet, and a breakable glyph alone in its segment never breaks.
		send(glyph_req(16'd0, 8'hFF, MAX16, 1'b1));
		r = stray_req();
		r.req_type = REQ_UNKNOWN;
		send(r);
		send(glyph_req(16'd255, 8'd0, 16'd0, 1'b0));
		send(end_req(16'd255));
		send(end_req(16'd0));
		drain(8);
		write_width(24'd1000);
		send(load_req(16'd10));
		send(load_req(16'd20));
		send(load_req(16'd20));
		send(glyph_req(16'd0, 8'd5, 16'd2000, 1'b1));
		send(glyph_req(16'd5, 8'd5, 16'd100, 1'b1));
		send(glyph_req(16'd10, 8'd10, 16'd100, 1'b0));
		// This glyph passes two run ends, but the run pointer moves by one.
		send(glyph_req(16'd30, 8'd4, 16'd100, 1'b0));
		send(glyph_req(16'd25, 8'd4, 16'd100, 1'b0));
		send(glyph_req(16'd40, 8'd4, 16'd100, 1'b0));
		send(end_req(16'd0));
		// A run ending at byte zero closes an empty segment on the first glyph.
		send(load_req(16'd0));
		send(glyph_req(16'd0, 8'd1, 16'd1, 1'b0));
		send(glyph_req(16'd1, 8'd1, 16'd1, 1'b1));
		send(end_req(16'd2));
		send(load_req(MAX16));
		send(glyph_req(MAX16, 8'hFF, MAX16, 1'b1));
		send(end_req(MAX16));

		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: phase_width = 24'($urandom_range(2000, 20000));
				1: phase_width = 24'd0;
				2: phase_width = MAX24;
				3: phase_width = 24'($urandom);
				default: phase_width = 24'($urandom_range(500, 8000));
			endcase
			drain(8);
			write_width(phase_width);
			if (ph == 4)
				calm = 1'b1;
			target = items_done + PHASE_ITEMS;
			if (ph == 0)
				paragraph(1'b1);
			if (ph == 2)
				long_paragraph();
			while (items_done < target) begin
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(1, 8)) send(stray_req());
				else
					paragraph(1'b0);
				if ($urandom_range(0, 9) == 0)
					drain(0);
			end
		end

		drain(20);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: greedy_line_wrapper.f
design/glw_pkg.sv
design/glw_ram.sv
design/glw_front.sv
design/glw_back.sv
design/greedy_line_wrapper.sv
sim/testbench.sv
